// File: rtl/four_thruster_mixer_with_deadband_assert.svh
// Assertion macros used by the mixer top module.
`ifndef FOUR_THRUSTER_MIXER_WITH_DEADBAND_ASSERT_SVH
`define FOUR_THRUSTER_MIXER_WITH_DEADBAND_ASSERT_SVH

`ifndef SYNTHESIS

// Condition that must hold on every clock edge out of reset.
`define TMIX_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Trigger in one cycle implies the consequence in the next.
`define TMIX_ASSERT_NEXT(lbl, clk, rstn, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (cons)) else $error(msg);

`else

`define TMIX_ASSERT(lbl, clk, rstn, prop, msg)
`define TMIX_ASSERT_NEXT(lbl, clk, rstn, trig, cons, msg)

`endif

`endif

// File: rtl/tmix_pkg.sv
package tmix_pkg;

	localparam logic [15:0] CENTER_PW      = 16'd1500;
	localparam logic [16:0] PAIR_SUM_LIMIT = 17'd3000;
	localparam logic [15:0] MIRROR_BASE    = 16'd2500;
	localparam logic [10:0] DEADBAND_RESET = 11'd50;

	typedef logic [2:0] mode_t;

	localparam mode_t MODE_NONE  = 3'd0;
	localparam mode_t MODE_ROT   = 3'd1;
	localparam mode_t MODE_FWD   = 3'd2;
	localparam mode_t MODE_DIAG  = 3'd3;
	localparam mode_t MODE_TURN  = 3'd4;
	localparam mode_t MODE_SIDE  = 3'd5;

	// comparison codes {r>f, r+f>3000, r>1500, f>1500}
	localparam logic [3:0] CODE_ALL_LOW   = 4'd0;
	localparam logic [3:0] CODE_ALL_HIGH  = 4'd15;
	localparam logic [3:0] CODE_FWD_LEAD  = 4'd7;
	localparam logic [3:0] CODE_ROT_LEAD  = 4'd8;
	localparam logic [3:0] CODE_SPLIT_FWD = 4'd5;
	localparam logic [3:0] CODE_SPLIT_ROT = 4'd10;
	localparam logic [3:0] CODE_FWD_ONLY  = 4'd1;
	localparam logic [3:0] CODE_ROT_ONLY  = 4'd14;

	typedef struct packed {
		logic [15:0] a;
		logic [15:0] b;
		logic [15:0] c;
		logic [15:0] d;
	} thrust_t;

endpackage

// File: rtl/four_thruster_mixer_with_deadband.sv
// Four-thruster mixer with deadband. Each request on the input channel is one
// control frame; each produces exactly one result request two registers later
// (input register, then the result register that also holds the mixing state).
// A new frame is taken every cycle, so sustained rate is one frame per clock as
// long as the result side does not stall; the single pass of deadband, compare
// and add logic between the two registers sets that figure. The thruster
// outputs and mix_mode are the mixer state itself: with no mode selected since
// reset they read zero and 0. Write cfg_data (deadband half width, reset 50)
// only while no frame is in flight.
`include "four_thruster_mixer_with_deadband_assert.svh"

module four_thruster_mixer_with_deadband
	import tmix_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [10:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] rotate_cmd,
	input  logic [15:0] forward_cmd,
	input  logic [15:0] vertical_cmd,
	input  logic        sideways_flag,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] thrust_a,
	output logic [15:0] thrust_b,
	output logic [15:0] thrust_c,
	output logic [15:0] thrust_d,
	output logic [15:0] vertical_out,
	output logic [2:0]  mix_mode
);

	logic [10:0] deadband_q;

	logic        valid_s1;
	logic [15:0] rot_s1;
	logic [15:0] fwd_s1;
	logic [15:0] vert_s1;
	logic        side_s1;

	logic        out_valid_q;
	mode_t       mode_q;
	thrust_t     held_q;
	logic [15:0] vert_q;

	logic        out_free;
	logic        advance;
	logic [15:0] rot_db;
	logic [15:0] fwd_db;
	logic [15:0] vert_db;
	mode_t       mode_next;
	thrust_t     thrust_next;

	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q <= DEADBAND_RESET;
		end else if (cfg_we) begin
			deadband_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			rot_s1  <= rotate_cmd;
			fwd_s1  <= forward_cmd;
			vert_s1 <= vertical_cmd;
			side_s1 <= sideways_flag;
		end
	end

	tmix_snap u_snap_rot (.cmd(rot_s1),  .width(deadband_q), .snapped(rot_db));
	tmix_snap u_snap_fwd (.cmd(fwd_s1),  .width(deadband_q), .snapped(fwd_db));
	tmix_snap u_snap_vert(.cmd(vert_s1), .width(deadband_q), .snapped(vert_db));

	tmix_mix u_mix (
		.rot        (rot_db),
		.fwd        (fwd_db),
		.side       (side_s1),
		.mode_prev  (mode_q),
		.thrust_prev(held_q),
		.mode_next  (mode_next),
		.thrust_next(thrust_next)
	);

	// mode and held thrust are state and result at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			mode_q      <= MODE_NONE;
			held_q      <= '0;
		end else begin
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
			if (advance) begin
				mode_q <= mode_next;
				held_q <= thrust_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			vert_q <= vert_db;
		end
	end

	assign out_valid    = out_valid_q;
	assign thrust_a     = held_q.a;
	assign thrust_b     = held_q.b;
	assign thrust_c     = held_q.c;
	assign thrust_d     = held_q.d;
	assign vertical_out = vert_q;
	assign mix_mode     = mode_q;

	`TMIX_ASSERT(a_mode_range, clk, arst_n, mode_q <= MODE_SIDE, "mix mode out of range")
	`TMIX_ASSERT_NEXT(a_mode_sticky, clk, arst_n, mode_q != MODE_NONE, mode_q != MODE_NONE, "mode fell back to none")
	`TMIX_ASSERT_NEXT(a_side_mode, clk, arst_n, advance && side_s1, mode_q == MODE_SIDE, "sideways frame did not select mode five")
	`TMIX_ASSERT(a_none_zero, clk, arst_n, (mode_q != MODE_NONE) || (held_q == '0), "thrust nonzero before any mode")

endmodule

// File: rtl/tmix_snap.sv
module tmix_snap
	import tmix_pkg::*;
(
	input  logic [15:0] cmd,
	input  logic [10:0] width,
	output logic [15:0] snapped
);

	logic [16:0] cmd_plus_w;
	logic [11:0] upper;
	logic        in_band;

	// 1500 - w < cmd is tested as cmd + w > 1500, so no signed math is needed
	assign cmd_plus_w = {1'b0, cmd} + {6'b0, width};
	assign upper      = {1'b0, width} + CENTER_PW[11:0];
	assign in_band    = (cmd_plus_w > {1'b0, CENTER_PW}) && (cmd < {4'b0, upper});
	assign snapped    = in_band ? CENTER_PW : cmd;

endmodule

// File: rtl/tmix_mix.sv
module tmix_mix
	import tmix_pkg::*;
(
	input  logic [15:0] rot,
	input  logic [15:0] fwd,
	input  logic        side,
	input  mode_t       mode_prev,
	input  thrust_t     thrust_prev,
	output mode_t       mode_next,
	output thrust_t     thrust_next
);

	logic [16:0] pair_sum;
	logic [3:0]  code;
	logic [15:0] sum_a;
	logic [15:0] diff_c;
	logic [15:0] mirror;

	assign pair_sum = {1'b0, rot} + {1'b0, fwd};
	assign code     = {rot > fwd, pair_sum > PAIR_SUM_LIMIT, rot > CENTER_PW, fwd > CENTER_PW};
	assign sum_a    = rot + fwd - CENTER_PW;
	assign diff_c   = CENTER_PW - rot + fwd;
	assign mirror   = MIRROR_BASE - rot;

	always_comb begin
		if (side) begin
			mode_next = MODE_SIDE;
		end else begin
			case (code) inside
				CODE_ALL_LOW, CODE_ALL_HIGH:    mode_next = MODE_ROT;
				CODE_FWD_LEAD, CODE_ROT_LEAD:   mode_next = MODE_FWD;
				CODE_SPLIT_FWD, CODE_SPLIT_ROT: mode_next = MODE_DIAG;
				CODE_FWD_ONLY, CODE_ROT_ONLY:   mode_next = MODE_TURN;
				default:                        mode_next = mode_prev;
			endcase
		end
	end

	always_comb begin
		case (mode_next)
			MODE_ROT:  thrust_next = '{a: rot,   b: rot,    c: diff_c, d: diff_c};
			MODE_FWD:  thrust_next = '{a: fwd,   b: fwd,    c: diff_c, d: diff_c};
			MODE_DIAG: thrust_next = '{a: sum_a, b: sum_a,  c: fwd,    d: fwd};
			MODE_TURN: thrust_next = '{a: sum_a, b: sum_a,  c: mirror, d: mirror};
			MODE_SIDE: thrust_next = '{a: rot,   b: mirror, c: rot,    d: mirror};
			// no mode yet: keep what is shown
			default:   thrust_next = thrust_prev;
		endcase
	end

endmodule
